// ===== rtl/core/orc_pkg.sv =====
// orc_pkg: shared types and codes of the overwriting ring with reader cursors
// no dependencies; imported by the interfaces, the top level and orc_cursor

package orc_pkg;

   localparam int SEQ_W = 64;
   localparam int WORD_W = 32;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_PUSH   = 2'd0,
      ST_DATA   = 2'd1,
      ST_CAUGHT = 2'd2
   } status_type;

   typedef struct packed {
      op_type              opcode;
      logic [WORD_W-1:0]   payload;
      logic [SEQ_W-1:0]    read_cursor;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [SEQ_W-1:0]    next_cursor;
      logic [SEQ_W-1:0]    dropped;
      logic [SEQ_W-1:0]    head_seq;
   } rsp_type;

endpackage

// ===== rtl/core/orc_req_if.sv =====
// orc_req_if: request channel of the ring, valid/ready with push or read payload
// depends on orc_pkg

interface orc_req_if;
   import orc_pkg::*;

   logic                valid;
   logic                ready;
   op_type              opcode;
   logic [WORD_W-1:0]   payload;
   logic [SEQ_W-1:0]    read_cursor;

   modport source (output valid, output opcode, output payload, output read_cursor,
                   input ready);
   modport sink   (input valid, input opcode, input payload, input read_cursor,
                   output ready);
endinterface

// ===== rtl/core/orc_rsp_if.sv =====
// orc_rsp_if: response channel of the ring, valid/ready with status and cursors
// depends on orc_pkg

interface orc_rsp_if;
   import orc_pkg::*;

   logic                valid;
   logic                ready;
   status_type          status;
   logic [WORD_W-1:0]   data;
   logic [SEQ_W-1:0]    next_cursor;
   logic [SEQ_W-1:0]    dropped;
   logic [SEQ_W-1:0]    head_seq;

   modport source (output valid, output status, output data, output next_cursor,
                   output dropped, output head_seq, input ready);
   modport sink   (input valid, input status, input data, input next_cursor,
                   input dropped, input head_seq, output ready);
endinterface

// ===== rtl/core/overwriting_ring_with_reader_cursors.sv =====
// overwriting_ring_with_reader_cursors: top level of the broadcast ring
// depends on orc_pkg, orc_req_if, orc_rsp_if, orc_ram and orc_cursor
//
//   channel   direction  handshake      payload
//   req_ch    in         valid/ready    opcode, payload, read_cursor
//   rsp_ch    out        valid/ready    status, data, next_cursor, dropped, head_seq
//
// one request per cycle sustained while responses are taken; from acceptance to response
// a request passes the request register, then the slot ram read and response register
// a stalled response holds both stages; the request register still fills if empty
// reset clears the head sequence and the stage valids; slot contents stay undefined
// until pushed

module overwriting_ring_with_reader_cursors
   import orc_pkg::*;
#(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic           clock,
   input  logic           reset,
   orc_req_if.sink        req_ch,
   orc_rsp_if.source      rsp_ch
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);

   logic              s1_valid_ff, s1_valid_in;
   req_type           s1_ff;
   logic              s2_valid_ff, s2_valid_in;
   rsp_type           s2_ff;
   logic [SEQ_W-1:0]  head_ff, head_in;
   logic [ADDR_W-1:0] head_idx_ff, head_idx_in;

   logic              advance;
   logic              take;
   logic              fire;
   logic              push;
   rsp_type           calc;
   logic [ADDR_W-1:0] rd_idx;
   logic [63:0]       wide_wr;
   logic [63:0]       wide_rd;
   logic [DATA_WIDTH-1:0] ram_q;

   assign advance      = !s2_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance || !s1_valid_ff;
   assign take         = req_ch.valid && req_ch.ready;
   assign fire         = s1_valid_ff && advance;
   assign push         = fire && (s1_ff.opcode == OP_PUSH);

   orc_cursor #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_cursor (
      .req      (s1_ff),
      .head     (head_ff),
      .head_idx (head_idx_ff),
      .rsp      (calc),
      .rd_idx   (rd_idx)
   );

   assign wide_wr = 64'(s1_ff.payload);

   orc_ram #(
      .WIDTH  (DATA_WIDTH),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_slots (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (head_idx_ff),
      .wr_data (wide_wr[DATA_WIDTH-1:0]),
      .rd_en   (fire && (s1_ff.opcode == OP_READ)),
      .rd_addr (rd_idx),
      .rd_data (ram_q)
   );

   always_comb begin
      s1_valid_in = (s1_valid_ff && !advance) || take;
      s2_valid_in = fire || (s2_valid_ff && !rsp_ch.ready);
      head_in     = head_ff;
      head_idx_in = head_idx_ff;
      if (push) begin
         head_in     = head_ff + SEQ_W'(1);
         head_idx_in = (head_idx_ff == LAST_IDX) ? '0 : head_idx_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         head_ff     <= '0;
         head_idx_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         head_ff     <= head_in;
         head_idx_ff <= head_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_ff.opcode      <= req_ch.opcode;
         s1_ff.payload     <= req_ch.payload;
         s1_ff.read_cursor <= req_ch.read_cursor;
      end
      if (fire) begin
         s2_ff <= calc;
      end
   end

   assign wide_rd            = 64'(ram_q);
   assign rsp_ch.valid       = s2_valid_ff;
   assign rsp_ch.status      = s2_ff.status;
   assign rsp_ch.data        = (s2_ff.status == ST_DATA) ? wide_rd[WORD_W-1:0] : '0;
   assign rsp_ch.next_cursor = s2_ff.next_cursor;
   assign rsp_ch.dropped     = s2_ff.dropped;
   assign rsp_ch.head_seq    = s2_ff.head_seq;

endmodule

// ===== rtl/core/orc_ram.sv =====
// orc_ram: generic single write port, single read port ram with registered read
// no dependencies

module orc_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/orc_cursor.sv =====
// orc_cursor: cursor check, clamp and slot index for one registered request
// depends on orc_pkg

module orc_cursor
   import orc_pkg::*;
#(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  req_type           req,
   input  logic [SEQ_W-1:0]  head,
   input  logic [ADDR_W-1:0] head_idx,
   output rsp_type           rsp,
   output logic [ADDR_W-1:0] rd_idx
);

   localparam logic [SEQ_W-1:0]  DEPTH_SEQ = SEQ_W'(DEPTH);
   localparam logic [ADDR_W:0]   DEPTH_IDX = (ADDR_W + 1)'(DEPTH);

   logic [SEQ_W-1:0] lag;
   logic             caught;
   logic             over;
   logic [ADDR_W:0]  lag_n;
   logic [ADDR_W:0]  head_x;
   logic [ADDR_W:0]  idx_x;

   always_comb begin
      lag    = head - req.read_cursor;
      caught = req.read_cursor >= head;
      over   = lag > DEPTH_SEQ;
      lag_n  = over ? DEPTH_IDX : lag[ADDR_W:0];
      head_x = {1'b0, head_idx};
      // walk back from the write slot by the distance to the cursor
      if (head_x >= lag_n) begin
         idx_x = head_x - lag_n;
      end else begin
         idx_x = head_x + DEPTH_IDX - lag_n;
      end
      rd_idx = idx_x[ADDR_W-1:0];

      rsp.status      = ST_PUSH;
      rsp.next_cursor = '0;
      rsp.dropped     = '0;
      rsp.head_seq    = head + SEQ_W'(1);
      if (req.opcode == OP_READ) begin
         rsp.head_seq = head;
         if (caught) begin
            rsp.status      = ST_CAUGHT;
            rsp.next_cursor = req.read_cursor;
         end else begin
            rsp.status = ST_DATA;
            if (over) begin
               rsp.dropped     = lag - DEPTH_SEQ;
               rsp.next_cursor = head - DEPTH_SEQ + SEQ_W'(1);
            end else begin
               rsp.next_cursor = req.read_cursor + SEQ_W'(1);
            end
         end
      end
   end

endmodule

// ===== tb/ring_cursor_checker.sv =====
// ring_cursor_checker: predicts the ring's responses and checks every accepted one
// depends on orc_pkg, orc_req_if and orc_rsp_if; instantiated by testbench
`timescale 1ns / 100ps

module ring_cursor_checker
   import orc_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic   clock,
   input  logic   reset,
   orc_req_if     req_ch,
   orc_rsp_if     rsp_ch,
   output int     fail_count,
   output int     waiting
);

   typedef struct packed {
      status_type          status;
      logic [WORD_W-1:0]   data;
      logic [SEQ_W-1:0]    next_cursor;
      logic [SEQ_W-1:0]    dropped;
      logic [SEQ_W-1:0]    head_seq;
   } ring_result_type;

   logic [WORD_W-1:0]   slot_copy [DEPTH];
   logic [SEQ_W-1:0]    head_model;
   logic [SEQ_W-1:0]    oldest_seq;
   logic [SEQ_W-1:0]    cursor;
   ring_result_type     want_rsp;
   ring_result_type     due_rsp_q[$];

   task automatic check_field(input string name, input logic [SEQ_W-1:0] want,
                              input logic [SEQ_W-1:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
   endtask

   initial begin
      fail_count = 0;
      waiting = 0;
      head_model = '0;
   end

   always @(posedge clock) begin
      if (reset) begin
         head_model = '0;
         due_rsp_q.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            want_rsp = '0;
            if (req_ch.opcode == OP_PUSH) begin
               slot_copy[head_model % DEPTH] = req_ch.payload;
               head_model = head_model + 1;
               want_rsp.status = ST_PUSH;
            end else if (req_ch.read_cursor >= head_model) begin
               want_rsp.status = ST_CAUGHT;
               want_rsp.next_cursor = req_ch.read_cursor;
            end else begin
               oldest_seq = (head_model > SEQ_W'(DEPTH)) ? head_model - SEQ_W'(DEPTH) : '0;
               cursor = req_ch.read_cursor;
               // reader fell behind the ring, skip forward to the oldest held entry
               if (cursor < oldest_seq) begin
                  want_rsp.dropped = oldest_seq - cursor;
                  cursor = oldest_seq;
               end
               want_rsp.status = ST_DATA;
               want_rsp.data = slot_copy[cursor % DEPTH];
               want_rsp.next_cursor = cursor + 1;
            end
            want_rsp.head_seq = head_model;
            due_rsp_q.push_back(want_rsp);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_rsp_q.size() == 0) begin
               fail_count++;
               $display("%0t: response with none expected, status %0d data %h head_seq %h",
                        $time, rsp_ch.status, rsp_ch.data, rsp_ch.head_seq);
            end else begin
               want_rsp = due_rsp_q.pop_front();
               check_field("status", SEQ_W'(want_rsp.status), SEQ_W'(rsp_ch.status));
               check_field("data", SEQ_W'(want_rsp.data), SEQ_W'(rsp_ch.data));
               check_field("next_cursor", want_rsp.next_cursor, rsp_ch.next_cursor);
               check_field("dropped", want_rsp.dropped, rsp_ch.dropped);
               check_field("head_seq", want_rsp.head_seq, rsp_ch.head_seq);
            end
         end
      end
      waiting = due_rsp_q.size();
   end

endmodule

// ===== tb/testbench.sv =====
// testbench: drives push and read requests into the ring with random stalls on both sides
// depends on orc_pkg, orc_req_if, orc_rsp_if, the ring top level and ring_cursor_checker
`timescale 1ns / 100ps

module testbench;
   import orc_pkg::*;

   localparam int RING_DEPTH   = 256;
   localparam int RANDOM_ITEMS = 1140;
   localparam int IDLE_LIMIT   = 5000;

   logic               clock;
   logic               reset;
   int                 fail_count;
   int                 waiting;
   int                 idle_cycles;
   logic               no_gaps;
   logic [SEQ_W-1:0]   pushes_sent;

   orc_req_if req_ch();
   orc_rsp_if rsp_ch();

   overwriting_ring_with_reader_cursors #(
      .DEPTH      (RING_DEPTH),
      .DATA_WIDTH (32)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   ring_cursor_checker #(
      .DEPTH (RING_DEPTH)
   ) checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .fail_count (fail_count),
      .waiting    (waiting)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   task automatic send_request(input op_type op, input logic [WORD_W-1:0] word,
                               input logic [SEQ_W-1:0] cursor);
      int gap;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.payload <= word;
      req_ch.read_cursor <= cursor;
      do
         @(posedge clock);
      while (!req_ch.ready);
      if (op == OP_PUSH)
         pushes_sent = pushes_sent + 1;
   endtask

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // response side stalls
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(50, 200)) @(posedge clock);
         else
            repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   initial begin
      logic [SEQ_W-1:0]   cursor;
      logic [SEQ_W-1:0]   span;
      int                 push_pct;
      int                 kind;
      reset <= 1'b1;
      no_gaps = 1'b0;
      pushes_sent = '0;
      idle_cycles <= 0;
      req_ch.valid <= 1'b0;
      req_ch.opcode <= OP_PUSH;
      req_ch.payload <= '0;
      req_ch.read_cursor <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty ring, then a few entries read back and the caught-up edge
      send_request(OP_READ, 32'h0, 64'h0);
      send_request(OP_READ, 32'h0, '1);
      send_request(OP_PUSH, 32'h0, 64'h0);
      send_request(OP_PUSH, 32'hFFFF_FFFF, 64'h0);
      send_request(OP_PUSH, 32'hA5A5_5A5A, 64'h0);
      send_request(OP_READ, 32'h0, 64'h0);
      send_request(OP_READ, 32'h0, 64'h1);
      send_request(OP_READ, 32'h0, 64'h2);
      send_request(OP_READ, 32'h0, 64'h3);
      send_request(OP_READ, 32'h0, 64'h8000_0000_0000_0000);
      send_request(OP_PUSH, 32'h8000_0001, '1);
      send_request(OP_READ, 32'hFFFF_FFFF, 64'h3);
      send_request(OP_READ, 32'h5A5A_A5A5, 64'h2);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 128 == 0)
            no_gaps = ($urandom_range(0, 9) < 3);
         // fill past the ring depth early so the clamp gets exercised
         push_pct = (i < 300) ? 80 : 50;
         if ($urandom_range(0, 99) < push_pct) begin
            send_request(OP_PUSH, $urandom, {$urandom, $urandom});
         end else begin
            kind = $urandom_range(0, 9);
            span = (pushes_sent < SEQ_W'(RING_DEPTH)) ? pushes_sent : SEQ_W'(RING_DEPTH);
            if (kind <= 3 && pushes_sent != 0)
               cursor = pushes_sent - 1 - SEQ_W'($urandom_range(0, int'(span) - 1));
            else if (kind == 4 && pushes_sent >= SEQ_W'(RING_DEPTH))
               cursor = pushes_sent - SEQ_W'(RING_DEPTH);
            else if (kind == 5 && pushes_sent > SEQ_W'(RING_DEPTH))
               cursor = pushes_sent - SEQ_W'(RING_DEPTH) - 1;
            else if (kind == 6 && pushes_sent > SEQ_W'(RING_DEPTH))
               cursor = SEQ_W'($urandom_range(0, int'(pushes_sent) - RING_DEPTH - 1));
            else if (kind == 7)
               cursor = {$urandom, $urandom};
            else if (kind == 8)
               cursor = pushes_sent + SEQ_W'($urandom_range(0, 3));
            else
               cursor = pushes_sent;
            send_request(OP_READ, $urandom, cursor);
         end
      end
      req_ch.valid <= 1'b0;

      while (waiting != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/orc_pkg.sv
rtl/core/orc_req_if.sv
rtl/core/orc_rsp_if.sv
rtl/core/orc_ram.sv
rtl/core/orc_cursor.sv
rtl/core/overwriting_ring_with_reader_cursors.sv
tb/ring_cursor_checker.sv
tb/testbench.sv
